>>> rtl/ipdt_pkg.sv
// Shared constants, types and a helper function for the IR pulse distance transmitter.
// No dependencies; the other RTL files refer to this package by scoped names, the testbench imports it.
`default_nettype none

package ipdt_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;
    localparam int TICK_W     = 20;
    localparam int UNIT_W     = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MSB_FIRST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_MARK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_SPACE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT        = 2'd3;

    localparam logic              RST_MSB_FIRST  = 1'b1;
    localparam logic [TICK_W-1:0] RST_LEAD_MARK  = 20'd9000;
    localparam logic [TICK_W-1:0] RST_LEAD_SPACE = 20'd4500;
    localparam logic [UNIT_W-1:0] RST_UNIT       = 19'd562;

    typedef struct packed {
        logic              msb_first;
        logic [TICK_W-1:0] lead_mark;
        logic [TICK_W-1:0] lead_space;
        logic [UNIT_W-1:0] unit;
    } t_cfg;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic       is_push;
        logic [7:0] data;
    } t_cmd;

    function automatic logic [7:0] reverse8(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ipdt_if.sv
// Channel interfaces of the IR pulse distance transmitter: request, result and configuration.
// Depends on ipdt_pkg for the field widths.
`default_nettype none

interface ipdt_item_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] byte_value;

    modport source (output valid, output mode, output byte_value, input ready);
    modport sink   (input valid, input mode, input byte_value, output ready);
endinterface

interface ipdt_result_if;
    logic valid;
    logic ready;
    logic carrier_on;
    logic busy_res;
    logic push_dropped;

    modport source (output valid, output carrier_on, output busy_res, output push_dropped,
                    input ready);
    modport sink   (input valid, input carrier_on, input busy_res, input push_dropped,
                    output ready);
endinterface

interface ipdt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ipdt_pkg::CFG_IDX_W-1:0]   index;
    logic [ipdt_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/ipdt_front.sv
// Front end: accepts requests, classifies them as pushes or ticks, and holds them in a
// two-entry queue for the back end. Depends on ipdt_pkg and ipdt_if.
`default_nettype none

module ipdt_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_msb_first,
    ipdt_item_if.sink        i_item,
    output ipdt_pkg::t_cmd   o_cmd,
    output logic             o_cmd_valid,
    input  wire logic        i_cmd_pop
);

    ipdt_pkg::t_cmd r_q [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    logic           push;
    logic           pop;
    ipdt_pkg::t_cmd in_cmd;

    assign i_item.ready = (r_cnt != 2'd2);
    assign push         = i_item.valid && i_item.ready;
    assign o_cmd_valid  = (r_cnt != 2'd0);
    assign pop          = o_cmd_valid && i_cmd_pop;
    assign o_cmd        = r_q[r_rd];

    // Bytes sent MSB first are stored reversed so the back end always shifts from bit 0.
    always_comb begin
        in_cmd.is_push = i_item.mode;
        in_cmd.data    = i_msb_first ? ipdt_pkg::reverse8(i_item.byte_value)
                                     : i_item.byte_value;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= in_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ipdt_back.sv
// Back end: byte FIFO, burst sequencer with its tick counter, and the result register.
// Depends on ipdt_pkg and ipdt_if.
`default_nettype none

module ipdt_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ipdt_pkg::t_cfg i_cfg,
    input  wire ipdt_pkg::t_cmd i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_pop,
    ipdt_result_if.source       o_result
);

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_LEAD_MARK  = 3'd1;
    localparam logic [2:0] PH_LEAD_SPACE = 3'd2;
    localparam logic [2:0] PH_BIT_MARK   = 3'd3;
    localparam logic [2:0] PH_BIT_SPACE  = 3'd4;
    localparam logic [2:0] PH_STOP_MARK  = 3'd5;

    localparam int TW = ipdt_pkg::TICK_W;
    localparam int PW = ipdt_pkg::PTR_W;

    logic [7:0]    r_mem [ipdt_pkg::FIFO_DEPTH];
    logic [7:0]    r_rd_data;
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [2:0]    r_phase, n_phase;
    logic [2:0]    r_bi, n_bi;
    logic [TW-1:0] r_tl, n_tl;

    logic          r_out_valid;
    logic          r_carrier;
    logic          r_busy;
    logic          r_dropped;

    logic          step;
    logic          wr_en;
    logic          carrier;
    logic          dropped;
    logic          busy;
    logic [PW-1:0] wp_inc;
    logic [PW-1:0] rp_inc;
    logic [PW-1:0] rd_addr;

    logic [TW-1:0] mark_len;
    logic [TW-1:0] space_len;
    logic [TW-1:0] unit_len;
    logic [TW:0]   triple;
    logic [TW-1:0] one_len;

    assign step      = i_cmd_valid && (!r_out_valid || o_result.ready);
    assign o_cmd_pop = step;

    assign wp_inc = (r_wp == ipdt_pkg::PTR_LAST) ? '0 : r_wp + PW'(1);
    assign rp_inc = (r_rp == ipdt_pkg::PTR_LAST) ? '0 : r_rp + PW'(1);

    // Segment lengths; a zero register counts as one tick, a one space saturates.
    assign mark_len  = (i_cfg.lead_mark == '0) ? TW'(1) : i_cfg.lead_mark;
    assign space_len = (i_cfg.lead_space == '0) ? TW'(1) : i_cfg.lead_space;
    assign unit_len  = (i_cfg.unit == '0) ? TW'(1) : {1'b0, i_cfg.unit};
    assign triple    = {unit_len, 1'b0} + {1'b0, unit_len};
    assign one_len   = (triple > {1'b0, ipdt_pkg::TICK_MAX}) ? ipdt_pkg::TICK_MAX
                                                             : triple[TW-1:0];

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_phase = r_phase;
        n_bi    = r_bi;
        n_tl    = r_tl;
        wr_en   = 1'b0;
        carrier = 1'b0;
        dropped = 1'b0;
        if (i_cmd.is_push) begin
            if (wp_inc == r_rp) begin
                dropped = 1'b1;
            end else begin
                wr_en = 1'b1;
                n_wp  = wp_inc;
            end
            carrier = (r_phase == PH_LEAD_MARK) || (r_phase == PH_BIT_MARK) ||
                      (r_phase == PH_STOP_MARK);
        end else begin
            if (r_tl == '0) begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (r_wp != r_rp) begin
                            n_phase = PH_LEAD_MARK;
                            n_tl    = mark_len;
                        end
                    end
                    PH_LEAD_MARK: begin
                        n_phase = PH_LEAD_SPACE;
                        n_tl    = space_len;
                    end
                    PH_LEAD_SPACE: begin
                        n_phase = PH_BIT_MARK;
                        n_bi    = 3'd0;
                        n_tl    = unit_len;
                    end
                    PH_BIT_MARK: begin
                        n_phase = PH_BIT_SPACE;
                        n_tl    = r_rd_data[r_bi] ? one_len : unit_len;
                    end
                    PH_BIT_SPACE: begin
                        n_tl = unit_len;
                        if (r_bi == 3'd7) begin
                            n_bi    = 3'd0;
                            n_rp    = rp_inc;
                            n_phase = (r_wp == rp_inc) ? PH_STOP_MARK : PH_BIT_MARK;
                        end else begin
                            n_bi    = r_bi + 3'd1;
                            n_phase = PH_BIT_MARK;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_bi    = 3'd0;
                        n_tl    = '0;
                    end
                endcase
            end
            if (n_phase != PH_IDLE) begin
                carrier = (n_phase == PH_LEAD_MARK) || (n_phase == PH_BIT_MARK) ||
                          (n_phase == PH_STOP_MARK);
                if (n_tl != '0) begin
                    n_tl = n_tl - TW'(1);
                end
            end
        end
        busy = (n_phase != PH_IDLE) || (n_wp != n_rp);
    end

    // The read follows the next read pointer, so the new byte is in r_rd_data by the
    // very next request. A written byte is read only after a whole leader or a whole
    // byte has gone out, long after its write has landed.
    assign rd_addr = step ? n_rp : r_rp;

    always_ff @(posedge i_clk) begin
        if (step && wr_en) begin
            r_mem[r_wp] <= i_cmd.data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_carrier <= carrier;
            r_busy    <= busy;
            r_dropped <= dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_phase     <= PH_IDLE;
            r_bi        <= 3'd0;
            r_tl        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_wp    <= n_wp;
                r_rp    <= n_rp;
                r_phase <= n_phase;
                r_bi    <= n_bi;
                r_tl    <= n_tl;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.carrier_on   = r_carrier;
    assign o_result.busy_res     = r_busy;
    assign o_result.push_dropped = r_dropped;

endmodule

`default_nettype wire

>>> rtl/ir_pulse_distance_transmitter_unit.sv
// IR pulse distance transmitter: one result per request (byte push or timebase tick),
// in request order. A request is accepted every cycle while the two-entry request queue
// has room; its result is registered when the back end takes it from the queue. The back
// end's single sequencer step per request sets the rate of one request per cycle, and the
// queue fills only while the result side stalls. Configuration writes are taken in any cycle.
// Depends on ipdt_pkg, ipdt_if, ipdt_front and ipdt_back.
`default_nettype none

module ir_pulse_distance_transmitter_unit (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ipdt_item_if.sink     i_item,
    ipdt_result_if.source o_result,
    ipdt_cfg_if.sink      i_cfg
);

    ipdt_pkg::t_cfg r_cfg;
    ipdt_pkg::t_cmd cmd;
    logic           cmd_valid;
    logic           cmd_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.msb_first  <= ipdt_pkg::RST_MSB_FIRST;
            r_cfg.lead_mark  <= ipdt_pkg::RST_LEAD_MARK;
            r_cfg.lead_space <= ipdt_pkg::RST_LEAD_SPACE;
            r_cfg.unit       <= ipdt_pkg::RST_UNIT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ipdt_pkg::REG_MSB_FIRST:  r_cfg.msb_first  <= i_cfg.data[0];
                ipdt_pkg::REG_LEAD_MARK:  r_cfg.lead_mark  <= i_cfg.data;
                ipdt_pkg::REG_LEAD_SPACE: r_cfg.lead_space <= i_cfg.data;
                ipdt_pkg::REG_UNIT:       r_cfg.unit       <= i_cfg.data[ipdt_pkg::UNIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ipdt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_msb_first (r_cfg.msb_first),
        .i_item      (i_item),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    ipdt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

>>> verif/tb_ir_pulse_distance_transmitter_unit.sv
// Testbench for the IR pulse distance transmitter: queued pushes and timebase ticks are driven with
// random gaps and a bit-exact prediction of every result is checked field by field.
// Depends on ipdt_pkg, the ipdt_if interfaces and ir_pulse_distance_transmitter_unit.
`default_nettype none

module tb_ir_pulse_distance_transmitter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ipdt_pkg::*;

    localparam logic MODE_TICK      = 1'b0;
    localparam logic MODE_PUSH      = 1'b1;
    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   SEG_SEARCH_MAX = 3000;

    typedef enum logic [2:0] {
        SEG_IDLE, SEG_LEAD_MARK, SEG_LEAD_SPACE, SEG_BIT_MARK, SEG_BIT_SPACE, SEG_STOP_MARK
    } t_seg;

    typedef struct packed {
        logic carrier_on;
        logic busy_res;
        logic push_dropped;
    } t_tx_obs;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ipdt_item_if   item_bus ();
    ipdt_result_if result_bus ();
    ipdt_cfg_if    cfg_bus ();

    ir_pulse_distance_transmitter_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus),
        .i_cfg    (cfg_bus)
    );

    always #5 i_clk = ~i_clk;

    // Transmitter state as the predictor sees it.
    t_cfg              model_cfg;
    logic [7:0]        tx_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr;
    logic [PTR_W-1:0]  rd_ptr;
    t_seg              seg;
    logic [3:0]        bit_pos;
    logic [TICK_W-1:0] ticks_left;

    t_cmd    req_backlog [$];
    t_tx_obs levels_due [$];
    int      fail_count = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // A zero length counts as one tick; anything past the counter range saturates.
    function automatic logic [TICK_W-1:0] seg_ticks(input int unsigned len);
        if (len == 0) return TICK_W'(1);
        if (len > 32'(TICK_MAX)) return TICK_MAX;
        return TICK_W'(len);
    endfunction

    function automatic logic is_mark(input t_seg s);
        return (s == SEG_LEAD_MARK) || (s == SEG_BIT_MARK) || (s == SEG_STOP_MARK);
    endfunction

    function automatic t_tx_obs tx_step(input logic is_push, input logic [7:0] data);
        t_tx_obs          obs;
        logic [PTR_W-1:0] wr_next;
        logic [7:0]       stored;
        obs = '0;
        if (is_push) begin
            wr_next = ptr_inc(wr_ptr);
            if (wr_next == rd_ptr) begin
                obs.push_dropped = 1'b1;
            end else begin
                for (int i = 0; i < 8; i++) stored[i] = model_cfg.msb_first ? data[7-i] : data[i];
                tx_fifo[wr_ptr] = stored;
                wr_ptr = wr_next;
            end
            obs.carrier_on = is_mark(seg);
        end else begin
            if (ticks_left == 0) begin
                case (seg)
                    SEG_IDLE: begin
                        if (wr_ptr != rd_ptr) begin
                            seg = SEG_LEAD_MARK;
                            ticks_left = seg_ticks(32'(model_cfg.lead_mark));
                        end
                    end
                    SEG_LEAD_MARK: begin
                        seg = SEG_LEAD_SPACE;
                        ticks_left = seg_ticks(32'(model_cfg.lead_space));
                    end
                    SEG_LEAD_SPACE: begin
                        seg = SEG_BIT_MARK;
                        bit_pos = '0;
                        ticks_left = seg_ticks(32'(model_cfg.unit));
                    end
                    SEG_BIT_MARK: begin
                        seg = SEG_BIT_SPACE;
                        if (tx_fifo[rd_ptr][bit_pos[2:0]])
                            ticks_left = seg_ticks(32'd3 * 32'(seg_ticks(32'(model_cfg.unit))));
                        else
                            ticks_left = seg_ticks(32'(model_cfg.unit));
                    end
                    SEG_BIT_SPACE: begin
                        bit_pos++;
                        if (bit_pos >= 4'd8) begin
                            bit_pos = '0;
                            rd_ptr = ptr_inc(rd_ptr);
                            seg = (wr_ptr == rd_ptr) ? SEG_STOP_MARK : SEG_BIT_MARK;
                        end else begin
                            seg = SEG_BIT_MARK;
                        end
                        ticks_left = seg_ticks(32'(model_cfg.unit));
                    end
                    default: begin
                        seg = SEG_IDLE;
                        bit_pos = '0;
                        ticks_left = '0;
                    end
                endcase
            end
            if (seg != SEG_IDLE) begin
                obs.carrier_on = is_mark(seg);
                if (ticks_left != 0) ticks_left--;
            end
        end
        obs.busy_res = (seg != SEG_IDLE) || (wr_ptr != rd_ptr);
        return obs;
    endfunction

    // Request driver.
    int   send_gap = 0;
    int   src_calm_left = 0;
    logic src_calm = 1'b0;
    t_cmd next_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_bus.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (item_bus.valid && item_bus.ready)
                levels_due.push_back(tx_step(item_bus.mode, item_bus.byte_value));
            if (src_calm_left == 0) begin
                src_calm = ($urandom_range(3) == 0);
                src_calm_left = $urandom_range(200, 30);
            end else begin
                src_calm_left--;
            end
            if (!item_bus.valid || item_bus.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    item_bus.valid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    next_req = req_backlog.pop_front();
                    item_bus.valid      <= 1'b1;
                    item_bus.mode       <= next_req.is_push;
                    item_bus.byte_value <= next_req.data;
                    send_gap = src_calm ? 0 : pick_gap();
                end else begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor; every few hundred results the receiver holds off for a long stretch.
    int      stall_left = 0;
    int      hold_left = 0;
    int      results_seen = 0;
    int      sink_calm_left = 0;
    logic    sink_calm = 1'b0;
    t_tx_obs due;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end else begin
            if (result_bus.valid && result_bus.ready) begin
                if (levels_due.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    fail_count++;
                end else begin
                    due = levels_due.pop_front();
                    if (result_bus.carrier_on !== due.carrier_on) begin
                        $error("carrier_on: expected %0b, got %0b",
                               due.carrier_on, result_bus.carrier_on);
                        fail_count++;
                    end
                    if (result_bus.busy_res !== due.busy_res) begin
                        $error("busy_res: expected %0b, got %0b",
                               due.busy_res, result_bus.busy_res);
                        fail_count++;
                    end
                    if (result_bus.push_dropped !== due.push_dropped) begin
                        $error("push_dropped: expected %0b, got %0b",
                               due.push_dropped, result_bus.push_dropped);
                        fail_count++;
                    end
                end
                results_seen++;
                if (results_seen % 700 == 300) hold_left = 400;
            end
            if (sink_calm_left == 0) begin
                sink_calm = ($urandom_range(3) == 0);
                sink_calm_left = $urandom_range(200, 30);
            end else begin
                sink_calm_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end else begin
                result_bus.ready <= 1'b1;
                stall_left = sink_calm ? 0 : pick_gap();
            end
        end
    end

    // Watchdog: ends the run when no channel moves anything for too long.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (item_bus.valid && item_bus.ready) ||
            (result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("ir_pulse_distance_transmitter_unit verification failed");
                $finish;
            end
        end
    end

    task automatic queue_req(input logic mode, input logic [7:0] data);
        t_cmd r;
        r.is_push = mode;
        r.data = data;
        req_backlog.push_back(r);
    endtask

    task automatic wait_quiet();
        do @(posedge i_clk);
        while (req_backlog.size() != 0 || item_bus.valid || levels_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        wait_quiet();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        case (idx)
            REG_MSB_FIRST:  model_cfg.msb_first  = value[0];
            REG_LEAD_MARK:  model_cfg.lead_mark  = value;
            REG_LEAD_SPACE: model_cfg.lead_space = value;
            REG_UNIT:       model_cfg.unit       = value[UNIT_W-1:0];
            default: ;
        endcase
    endtask

    // Sends single ticks until the transmitter reaches the wanted segment.
    task automatic tick_until(input t_seg target);
        int n;
        n = 0;
        while (seg != target && n < SEG_SEARCH_MAX) begin
            queue_req(MODE_TICK, 8'($urandom));
            wait_quiet();
            n++;
        end
    endtask

    initial begin
        int made;
        int run;
        int push_pct;
        item_bus.valid      = 1'b0;
        item_bus.mode       = MODE_TICK;
        item_bus.byte_value = '0;
        result_bus.ready    = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = REG_MSB_FIRST;
        cfg_bus.data        = '0;
        model_cfg.msb_first  = RST_MSB_FIRST;
        model_cfg.lead_mark  = RST_LEAD_MARK;
        model_cfg.lead_space = RST_LEAD_SPACE;
        model_cfg.unit       = RST_UNIT;
        wr_ptr     = '0;
        rd_ptr     = '0;
        seg        = SEG_IDLE;
        bit_pos    = '0;
        ticks_left = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Short segments, zero lengths included, so whole bursts fit in a few items.
        write_reg(REG_MSB_FIRST, 20'd1);
        write_reg(REG_LEAD_MARK, 20'd0);
        write_reg(REG_LEAD_SPACE, 20'd1);
        write_reg(REG_UNIT, 20'd0);
        queue_req(MODE_TICK, 8'hFF);
        queue_req(MODE_PUSH, 8'h80);
        tick_until(SEG_STOP_MARK);
        // A byte arriving during the stop mark must restart with a fresh leader.
        queue_req(MODE_PUSH, 8'h7F);
        queue_req(MODE_TICK, 8'h00);
        queue_req(MODE_TICK, 8'h00);
        queue_req(MODE_TICK, 8'h00);
        write_reg(REG_MSB_FIRST, 20'd0);
        queue_req(MODE_PUSH, 8'h00);
        queue_req(MODE_PUSH, 8'hFF);
        queue_req(MODE_PUSH, 8'h55);
        queue_req(MODE_PUSH, 8'hAA);
        // Enough pushes to fill the queue and overflow it once.
        repeat (11) queue_req(MODE_PUSH, 8'($urandom));

        for (int ph = 0; ph < 9; ph++) begin
            write_reg(REG_MSB_FIRST, 20'($urandom_range(1)));
            write_reg(REG_LEAD_MARK, 20'($urandom_range(6)));
            write_reg(REG_LEAD_SPACE, 20'($urandom_range(6)));
            write_reg(REG_UNIT, 20'($urandom_range(2)));
            case (ph % 3)
                0:       push_pct = 3;
                1:       push_pct = 8;
                default: push_pct = 25;
            endcase
            made = 0;
            while (made < 120) begin
                if ($urandom_range(99) < 3) begin
                    run = $urandom_range(18, 2);
                    repeat (run) queue_req(MODE_PUSH, 8'($urandom));
                    made += run;
                end else begin
                    queue_req(($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_TICK,
                              8'($urandom));
                    made++;
                end
            end
        end

        // Closing phase: three units past the counter range must saturate, not wrap.
        // The space loaded here outlasts the run, so nothing follows it.
        write_reg(REG_LEAD_MARK, 20'd0);
        write_reg(REG_LEAD_SPACE, 20'd0);
        write_reg(REG_UNIT, 20'd1);
        write_reg(REG_MSB_FIRST, 20'd0);
        tick_until(SEG_IDLE);
        queue_req(MODE_PUSH, 8'h01);
        tick_until(SEG_BIT_MARK);
        write_reg(REG_UNIT, 20'd349526);
        repeat (100) queue_req(MODE_TICK, 8'($urandom));
        repeat (16) queue_req(MODE_PUSH, 8'($urandom));
        repeat (150) begin
            queue_req(($urandom_range(99) < 5) ? MODE_PUSH : MODE_TICK, 8'($urandom));
        end
        write_reg(REG_LEAD_MARK, TICK_MAX);
        write_reg(REG_LEAD_SPACE, TICK_MAX);
        write_reg(REG_UNIT, 20'h7FFFF);
        repeat (50) queue_req(MODE_TICK, 8'($urandom));

        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && levels_due.size() == 0) begin
            $display("ir_pulse_distance_transmitter_unit verification clean");
        end else begin
            $display("ir_pulse_distance_transmitter_unit verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/ipdt_pkg.sv
rtl/ipdt_if.sv
rtl/ipdt_front.sv
rtl/ipdt_back.sv
rtl/ir_pulse_distance_transmitter_unit.sv
verif/tb_ir_pulse_distance_transmitter_unit.sv
